// ===== rtl/bwt_pkg.sv =====
// Shared types and constants for the inverse block-sorting transform
package bwt_pkg;

   localparam int BlockSizeDefault = 4096;
   localparam int AlphabetDefault  = 256;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusIdle    = 2'd1;
   localparam logic [1:0] StatusBadRow  = 2'd2;
   localparam logic [1:0] StatusOverrun = 2'd3;

   localparam logic OpLoad = 1'b0;
   localparam logic OpEmit = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] symbol_in;
      logic [11:0] row_start;
      logic       block_end;
   } req_word_type;

   typedef struct packed {
      logic [7:0] symbol_out;
      logic       final_out;
      logic [1:0] status;
   } rsp_word_type;

endpackage

// ===== rtl/bwt_inverse_transform_top.sv =====
// Top level of the inverse block-sorting transform decoder
//
// Usage: drive req_word with start high while busy is low; the word is taken
// at that edge. Load words (operation 0) bring last-column bytes; the word with
// block_end high also brings the primary index row. Emit words (operation 1)
// each give one response word, shown for one cycle with rsp_valid high; the
// receiver cannot stall, so it must take every response as it appears.
// Sequencing: a load reads the tally, then writes tally and rank; an emit
// reads the column/link memories, then gives the response. An emit with
// nothing pending or with a bad primary index answers in the next cycle. The
// load that ends a block starts a link-building pass: a tally prefix sweep
// over ALPHABET symbols (read, then write per symbol), a link pass over each
// kept byte (read column/rank, read base, write link), then a tally clear of
// all ALPHABET entries. The single-port tally memory and the per-entry link
// writes set these steps. busy is high throughout.
// Reset: all control state clears; the tally memory is cleared by a sweep over
// all ALPHABET entries after reset, during which busy stays high. The column, rank
// and link memories are not cleared.
module bwt_inverse_transform_top #(
   parameter int BLOCK_SIZE = bwt_pkg::BlockSizeDefault,
   parameter int ALPHABET   = bwt_pkg::AlphabetDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bwt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   output bwt_pkg::rsp_word_type rsp_word
);

   localparam int AW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
   localparam int CW = $clog2(BLOCK_SIZE + 1);
   localparam int SW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD_WR, ST_SUM_RD, ST_SUM_WR, ST_LINK_RD,
      ST_LINK_TL, ST_LINK_WR, ST_EMIT_RD, ST_EMIT_OUT
   } state_type;

   // memories
   logic [7:0]    column_mem [BLOCK_SIZE];
   logic [CW-1:0] rank_mem   [BLOCK_SIZE];
   logic [AW-1:0] link_mem   [BLOCK_SIZE];
   logic [CW-1:0] tally_mem  [ALPHABET];

   state_type     state_ff;
   logic [CW-1:0] fill_ff, remaining_ff, count_ff, sum_ff, kept_ff;
   logic [AW-1:0] walk_ff;
   logic [SW-1:0] sym_ff;
   logic          over_ff, bad_ff, end_ff, rsp_valid_ff;
   logic [11:0]   row_ff;
   bwt_pkg::rsp_word_type rsp_ff;

   logic [7:0]    col_rd_ff;
   logic [CW-1:0] rank_rd_ff, tally_rd_ff;
   logic [AW-1:0] link_rd_ff;

   logic [SW-1:0] sym_sat;
   logic          accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   // saturate a byte into the alphabet
   always_comb begin
      if ({24'd0, req_word.symbol_in} >= 32'(ALPHABET)) begin
         sym_sat = SW'(ALPHABET - 1);
      end else begin
         sym_sat = SW'(req_word.symbol_in);
      end
   end

   // tally memory: one port, registered read
   always_ff @(posedge clock) begin
      logic [SW-1:0] t_addr;
      t_addr = sym_ff;
      if (state_ff == ST_IDLE) t_addr = sym_sat;
      if (state_ff == ST_LINK_TL) t_addr = SW'(col_rd_ff);
      tally_rd_ff <= tally_mem[t_addr];
      if (state_ff == ST_CLEAR) begin
         tally_mem[sym_ff] <= '0;
      end else if (state_ff == ST_LOAD_WR && fill_ff < CW'(BLOCK_SIZE)) begin
         tally_mem[sym_ff] <= tally_rd_ff + CW'(1);
      end else if (state_ff == ST_SUM_WR) begin
         tally_mem[sym_ff] <= sum_ff;
      end
   end

   // column, rank and link memories
   always_ff @(posedge clock) begin
      logic [AW-1:0] r_addr;
      r_addr = count_ff[AW-1:0];
      if (state_ff == ST_EMIT_RD) r_addr = walk_ff;
      col_rd_ff  <= column_mem[r_addr];
      rank_rd_ff <= rank_mem[r_addr];
      link_rd_ff <= link_mem[r_addr];
      if (state_ff == ST_LOAD_WR) begin
         if (fill_ff < CW'(BLOCK_SIZE)) begin
            column_mem[fill_ff[AW-1:0]] <= 8'(sym_ff);
            rank_mem[fill_ff[AW-1:0]]   <= tally_rd_ff;
         end
      end
      if (state_ff == ST_LINK_WR) begin
         if (32'(tally_rd_ff) + 32'(rank_rd_ff) < 32'(BLOCK_SIZE)) begin
            link_mem[AW'(tally_rd_ff + rank_rd_ff)] <= count_ff[AW-1:0];
         end
      end
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         fill_ff <= '0;
         remaining_ff <= '0;
         count_ff <= '0;
         sum_ff <= '0;
         kept_ff <= '0;
         walk_ff <= '0;
         sym_ff <= '0;
         over_ff <= 1'b0;
         bad_ff <= 1'b0;
         end_ff <= 1'b0;
         row_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ff <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               sym_ff <= sym_ff + SW'(1);
               if (32'(sym_ff) == ALPHABET - 1) begin
                  sym_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if (req_word.operation == bwt_pkg::OpLoad) begin
                     sym_ff <= sym_sat;
                     end_ff <= req_word.block_end;
                     row_ff <= req_word.row_start;
                     if (fill_ff == '0) begin
                        remaining_ff <= '0;
                        over_ff <= 1'b0;
                        bad_ff <= 1'b0;
                     end
                     state_ff <= ST_LOAD_WR;
                  end else if (remaining_ff == '0) begin
                     rsp_ff <= '{symbol_out: 8'd0, final_out: 1'b0,
                                 status: bwt_pkg::StatusIdle};
                     rsp_valid_ff <= 1'b1;
                  end else if (bad_ff) begin
                     remaining_ff <= '0;
                     bad_ff <= 1'b0;
                     rsp_ff <= '{symbol_out: 8'd0, final_out: 1'b1,
                                 status: bwt_pkg::StatusBadRow};
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_EMIT_RD;
                  end
               end
            end
            ST_LOAD_WR: begin
               logic [CW-1:0] n;
               n = fill_ff;
               if (fill_ff < CW'(BLOCK_SIZE)) begin
                  n = fill_ff + CW'(1);
               end else begin
                  over_ff <= 1'b1;
               end
               if (end_ff) begin
                  kept_ff <= n;
                  remaining_ff <= n;
                  if (32'(row_ff) >= 32'(n)) begin
                     bad_ff <= 1'b1;
                     walk_ff <= '0;
                  end else begin
                     walk_ff <= AW'(row_ff);
                  end
                  fill_ff <= '0;
                  sym_ff <= '0;
                  sum_ff <= '0;
                  state_ff <= ST_SUM_RD;
               end else begin
                  fill_ff <= n;
                  state_ff <= ST_IDLE;
               end
            end
            // turn tallies into running bases
            ST_SUM_RD: state_ff <= ST_SUM_WR;
            ST_SUM_WR: begin
               sum_ff <= sum_ff + tally_rd_ff;
               sym_ff <= sym_ff + SW'(1);
               if (32'(sym_ff) == ALPHABET - 1) begin
                  count_ff <= '0;
                  state_ff <= (kept_ff == '0) ? ST_CLEAR : ST_LINK_RD;
               end else begin
                  state_ff <= ST_SUM_RD;
               end
            end
            // link pass: read column/rank, then base, then write link
            ST_LINK_RD: state_ff <= ST_LINK_TL;
            ST_LINK_TL: state_ff <= ST_LINK_WR;
            ST_LINK_WR: begin
               count_ff <= count_ff + CW'(1);
               if (count_ff + CW'(1) == kept_ff) begin
                  sym_ff <= '0;
                  state_ff <= ST_CLEAR;
               end else begin
                  state_ff <= ST_LINK_RD;
               end
            end
            ST_EMIT_RD: state_ff <= ST_EMIT_OUT;
            ST_EMIT_OUT: begin
               remaining_ff <= remaining_ff - CW'(1);
               walk_ff <= link_rd_ff;
               rsp_ff <= '{symbol_out: col_rd_ff,
                           final_out: (remaining_ff == CW'(1)),
                           status: over_ff ? bwt_pkg::StatusOverrun
                                           : bwt_pkg::StatusOk};
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== tb/bwt_inverse_transform_top_test.sv =====
// Self-checking testbench for the inverse block-sorting transform decoder
`timescale 1ns / 100ps

module bwt_inverse_transform_top_test;

   localparam int Depth      = bwt_pkg::BlockSizeDefault;
   localparam int Symbols    = bwt_pkg::AlphabetDefault;
   localparam int CycleLimit = 600000;
   localparam int SettleWait = 2 * Symbols + 2 * Depth + 200;

   typedef struct {
      bit                    drain;
      bwt_pkg::req_word_type word;
   } pending_item_type;

   logic                  clock;
   logic                  reset;
   logic                  start = 1'b0;
   logic                  busy;
   bwt_pkg::req_word_type req_word = '0;
   logic                  rsp_valid;
   bwt_pkg::rsp_word_type rsp_word;

   bwt_inverse_transform_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // Decoder state as the testbench sees it
   logic [7:0]  column_copy [Depth];
   logic [11:0] rank_copy   [Depth];
   logic [11:0] link_copy   [Depth];
   int          tally       [Symbols] = '{default: 0};
   int          fill_count = 0;
   int          walk_row   = 0;
   int          bytes_left = 0;
   bit          overflowed = 0;
   bit          row_bad    = 0;

   pending_item_type      send_queue[$];
   bwt_pkg::rsp_word_type expected_bytes[$];
   int                    error_count = 0;
   int                    cycle_count = 0;
   int                    gap_left    = 0;
   bit                    steady_run  = 0;
   int                    words_sent  = 0;

   // Report one mismatch and count it
   task automatic report_error(input string what);
      $display("ERROR at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Build successor links from the tally prefix sums, then clear tallies
   task automatic build_links(input int kept);
      int base [Symbols];
      int sum;
      int pos;
      sum = 0;
      for (int c = 0; c < Symbols; c++) begin
         base[c] = sum;
         sum += tally[c];
      end
      for (int j = 0; j < kept; j++) begin
         pos = base[column_copy[j]] + rank_copy[j];
         if (pos < Depth) link_copy[pos] = j[11:0];
      end
      for (int c = 0; c < Symbols; c++) tally[c] = 0;
   endtask

   // Advance the decoder state by one accepted word; queue any response
   task automatic decode_word(input bwt_pkg::req_word_type w);
      bwt_pkg::rsp_word_type r;
      int                    sym;
      if (w.operation == bwt_pkg::OpLoad) begin
         if (fill_count == 0) begin
            bytes_left = 0;
            overflowed = 0;
            row_bad    = 0;
         end
         sym = (w.symbol_in >= Symbols) ? Symbols - 1 : w.symbol_in;
         if (fill_count < Depth) begin
            column_copy[fill_count] = sym[7:0];
            rank_copy[fill_count]   = tally[sym][11:0];
            tally[sym]++;
            fill_count++;
         end else begin
            overflowed = 1;
         end
         if (w.block_end) begin
            build_links(fill_count);
            if (w.row_start >= fill_count) begin
               row_bad  = 1;
               walk_row = 0;
            end else begin
               walk_row = w.row_start;
            end
            bytes_left = fill_count;
            fill_count = 0;
         end
         return;
      end
      if (bytes_left == 0) begin
         r = '{symbol_out: 8'd0, final_out: 1'b0, status: bwt_pkg::StatusIdle};
      end else if (row_bad) begin
         bytes_left = 0;
         row_bad    = 0;
         r = '{symbol_out: 8'd0, final_out: 1'b1, status: bwt_pkg::StatusBadRow};
      end else begin
         r.symbol_out = column_copy[walk_row];
         walk_row     = link_copy[walk_row];
         bytes_left--;
         r.final_out  = (bytes_left == 0);
         r.status     = overflowed ? bwt_pkg::StatusOverrun : bwt_pkg::StatusOk;
      end
      expected_bytes = {expected_bytes, r};
   endtask

   // Clock
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Time-out guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_run || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Driver: present queued words, hold on busy, insert random gaps
   always @(posedge clock) begin
      bit                    drive_next;
      bwt_pkg::req_word_type next_word;
      pending_item_type      head;
      drive_next = 0;
      next_word  = req_word;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            decode_word(req_word);
            words_sent++;
            if (words_sent % 64 == 0) steady_run = ($urandom_range(0, 3) == 0);
            gap_left = pick_gap();
         end
         if (start && busy) begin
            drive_next = 1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (send_queue.size() > 0) begin
            if (send_queue[0].drain) begin
               if (expected_bytes.size() == 0) void'(send_queue.pop_front());
            end else begin
               head       = send_queue.pop_front();
               next_word  = head.word;
               drive_next = 1;
            end
         end
         start    <= drive_next;
         req_word <= next_word;
      end
   end

   // Monitor: compare every response word with the oldest expectation
   always @(posedge clock) begin
      bwt_pkg::rsp_word_type exp_word;
      if (!reset && rsp_valid) begin
         if (expected_bytes.size() == 0) begin
            report_error($sformatf("unexpected response %p", rsp_word));
         end else begin
            exp_word = expected_bytes.pop_front();
            if (rsp_word.symbol_out !== exp_word.symbol_out)
               report_error($sformatf("symbol_out %0h, expected %0h",
                                      rsp_word.symbol_out, exp_word.symbol_out));
            if (rsp_word.final_out !== exp_word.final_out)
               report_error($sformatf("final_out %0b, expected %0b",
                                      rsp_word.final_out, exp_word.final_out));
            if (rsp_word.status !== exp_word.status)
               report_error($sformatf("status %0d, expected %0d",
                                      rsp_word.status, exp_word.status));
         end
      end
   end

   task automatic push_load(input int sym, input bit last, input int row);
      pending_item_type p;
      p.drain = 0;
      p.word  = '{operation: bwt_pkg::OpLoad, symbol_in: sym[7:0],
                  row_start: row[11:0], block_end: last};
      send_queue = {send_queue, p};
   endtask

   task automatic push_emit();
      pending_item_type p;
      p.drain = 0;
      p.word  = '{operation: bwt_pkg::OpEmit, symbol_in: 8'($urandom),
                  row_start: 12'($urandom), block_end: 1'($urandom)};
      send_queue = {send_queue, p};
   endtask

   task automatic push_drain();
      pending_item_type p;
      p.drain = 1;
      p.word  = '0;
      send_queue = {send_queue, p};
   endtask

   // Queue one block of random bytes, with a valid or out-of-range row
   task automatic push_block(input int len, input int sym_top, input bit good_row);
      int row;
      row = good_row ? $urandom_range(0, len - 1) : $urandom_range(len, Depth - 1);
      for (int i = 0; i < len - 1; i++) push_load($urandom_range(0, sym_top), 0, $urandom);
      push_load($urandom_range(0, sym_top), 1, row);
   endtask

   // Stimulus
   initial begin
      int queued;
      int len;
      int emits;
      reset = 1;
      repeat (8) @(posedge clock);
      reset <= 0;

      // Emit before any block: nothing pending
      push_emit();
      // Single-byte block at the top symbol, then one emit too many
      push_load(255, 1, 0);
      push_emit();
      push_emit();
      // Extremes of the byte range, all bytes decoded
      push_load(0, 0, 12'hfff);
      push_load(255, 0, 0);
      push_load(0, 0, 0);
      push_load(128, 1, 2);
      repeat (4) push_emit();
      // Out-of-range row ends the block on the first emit
      push_load(7, 0, 0);
      push_load(7, 0, 0);
      push_load(3, 1, 4095);
      push_emit();
      push_emit();
      // New block while bytes are still pending
      push_load(1, 0, 0);
      push_load(2, 1, 1);
      push_emit();
      push_load(9, 1, 0);
      push_emit();
      push_drain();

      // Full block plus extra bytes: dropped and flagged, top row valid
      for (int i = 0; i < Depth + 3; i++)
         push_load($urandom_range(0, 255), (i == Depth + 2), Depth - 1);
      repeat (3) push_emit();
      push_load($urandom_range(0, 255), 1, 0);
      push_emit();
      push_drain();

      // Random blocks, mostly well formed
      queued = 0;
      while (queued < 550) begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 200)
                                            : $urandom_range(1, 12);
         push_block(len, ($urandom_range(0, 1) ? 255 : 3), ($urandom_range(0, 99) < 85));
         emits = len + $urandom_range(0, 2);
         if ($urandom_range(0, 9) == 0) emits = $urandom_range(0, len);
         repeat (emits) push_emit();
         queued += len + emits;
         if ($urandom_range(0, 15) == 0) push_drain();
      end

      wait (send_queue.size() == 0 && expected_bytes.size() == 0 && !start);
      repeat (SettleWait) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
